### rtl/core/pose_point_transform_assert.svh
// Assertion helpers shared by the pose transform RTL.
// Every macro samples on the rising edge of clk and is off while rst_n is low.
`ifndef POSE_POINT_TRANSFORM_ASSERT_SVH
`define POSE_POINT_TRANSFORM_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PPT_ASSERT_NOW(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("pose_point_transform: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define PPT_ASSERT_NEXT(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("pose_point_transform: next-cycle check failed");

`endif

### rtl/core/ppt_pkg.sv
`default_nettype none

package ppt_pkg;

    localparam int COORD_W    = 32;
    localparam int QUAT_W     = 32;
    localparam int CFG_DATA_W = (COORD_W > QUAT_W) ? COORD_W : QUAT_W;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] REG_ORIENT_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIENT_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORIENT_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ORIENT_W = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Z = 3'd6;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
    } ppt_point_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] out_x;
        logic signed [COORD_W-1:0] out_y;
        logic signed [COORD_W-1:0] out_z;
        logic                      bad_rotation;
    } ppt_result_t;

endpackage

`default_nettype wire

### rtl/core/pose_point_transform.sv
`default_nettype none
// Rotates each incoming Q16.16 point by the configured Q1.30 quaternion, normalized by its
// squared norm, adds the translation and saturates. One point is accepted per clock while the
// output is not stalled and the settle counter is zero; the restoring divider resolves one
// quotient bit per pipeline stage. The rotation matrix and the squared norm are rebuilt from
// the registers in a four-stage side pipeline, so after any register write the point channel
// stays not ready until the settle counter has counted down. An all-zero quaternion gives zero
// coordinates with bad_rotation set.

`include "pose_point_transform_assert.svh"

module pose_point_transform
    import ppt_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  point_valid,
    output logic                       point_ready,
    input  wire ppt_point_t            point,
    output logic                       result_valid,
    input  wire logic                  result_ready,
    output ppt_result_t                result
);

    localparam int CW = COORD_W;
    localparam int QW = QUAT_W;
    localparam int HW = QW;           // half of a matrix entry
    localparam int MW = 2 * QW;       // matrix entry and squared norm
    localparam int AW = CW + MW;      // row sum
    localparam int NW = AW + 1;       // rounded numerator
    localparam int QB = CW + 1;       // quotient bits
    localparam int RW = NW - QB;      // divider remainder
    localparam int SW = CW + 3;       // offset sum
    localparam logic [2:0] SETTLE = 3'd4;
    localparam logic signed [QW-1:0] Q_ONE = {2'b01, {(QW-2){1'b0}}};
    localparam logic signed [SW-1:0] OUT_MAX = SW'({1'b0, {(CW-1){1'b1}}});
    localparam logic signed [SW-1:0] OUT_MIN = -OUT_MAX - SW'(1);

    // Configuration registers.
    logic signed [QW-1:0] orient_reg [4];
    logic signed [CW-1:0] offset_reg [3];
    logic [2:0]           settle_cnt_reg;

    // Matrix side pipeline.
    logic signed [QW-1:0] qh_reg [4];
    logic signed [MW-1:0] sq_reg [4];
    logic signed [MW-1:0] xy_reg, xz_reg, yz_reg, wx_reg, wy_reg, wz_reg;
    logic signed [MW-1:0] c3_m_reg [3][3];
    logic signed [MW-1:0] c3_d_reg [3];
    logic signed [MW-1:0] m_reg [3][3];
    logic [MW-1:0]        dvs_reg;
    logic                 zero_reg;

    // Point pipeline.
    logic                      en;
    logic                      v_reg [5];
    logic signed [CW-1:0]      p_reg [3];
    logic signed [HW+CW-1:0]   ph_reg [3][3];
    logic signed [HW+CW:0]     pl_reg [3][3];
    logic signed [AW-1:0]      prod_reg [3][3];
    logic signed [AW-1:0]      acc_reg [3];
    logic [AW-2:0]             mag_reg [3];
    logic                      neg_reg [3];
    logic                      dv_v_reg [QB+1];
    logic [RW-1:0]             dv_rem_reg [QB+1][3];
    logic [QB-1:0]             dv_low_reg [QB+1][3];
    logic [QB-1:0]             dv_quo_reg [QB+1][3];
    logic                      dv_neg_reg [QB+1][3];
    logic                      f1_v_reg;
    logic signed [QB:0]        f1_r_reg [3];
    logic                      out_v_reg;
    ppt_result_t               out_reg;

    logic       big;
    logic [NW-1:0] num [3];
    logic signed [SW-1:0] osum [3];
    logic signed [CW-1:0] osat [3];

    assign en           = !out_v_reg || result_ready;
    assign cfg_ready    = 1'b1;
    assign point_ready  = en && (settle_cnt_reg == 3'd0);
    assign result_valid = out_v_reg;
    assign result       = out_reg;

    // Register file and settle counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            orient_reg[0]  <= '0;
            orient_reg[1]  <= '0;
            orient_reg[2]  <= '0;
            orient_reg[3]  <= Q_ONE;
            offset_reg[0]  <= '0;
            offset_reg[1]  <= '0;
            offset_reg[2]  <= '0;
            settle_cnt_reg <= SETTLE;
        end
        else if (cfg_valid && cfg_ready)
        begin
            settle_cnt_reg <= SETTLE;
            case (cfg_index)
                REG_ORIENT_X: orient_reg[0] <= cfg_data[QW-1:0];
                REG_ORIENT_Y: orient_reg[1] <= cfg_data[QW-1:0];
                REG_ORIENT_Z: orient_reg[2] <= cfg_data[QW-1:0];
                REG_ORIENT_W: orient_reg[3] <= cfg_data[QW-1:0];
                REG_OFFSET_X: offset_reg[0] <= cfg_data[CW-1:0];
                REG_OFFSET_Y: offset_reg[1] <= cfg_data[CW-1:0];
                REG_OFFSET_Z: offset_reg[2] <= cfg_data[CW-1:0];
                default: ;
            endcase
        end
        else if (settle_cnt_reg != 3'd0)
        begin
            settle_cnt_reg <= settle_cnt_reg - 3'd1;
        end
    end

    always_comb
    begin
        big = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            if (orient_reg[i] > Q_ONE || orient_reg[i] < -Q_ONE)
            begin
                big = 1'b1;
            end
        end
    end

    // The matrix is n times the rotation, so no normalization is needed until the divide.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            qh_reg[i] <= big ? (orient_reg[i] >>> 1) : orient_reg[i];
            sq_reg[i] <= qh_reg[i] * qh_reg[i];
        end
        xy_reg <= qh_reg[0] * qh_reg[1];
        xz_reg <= qh_reg[0] * qh_reg[2];
        yz_reg <= qh_reg[1] * qh_reg[2];
        wx_reg <= qh_reg[3] * qh_reg[0];
        wy_reg <= qh_reg[3] * qh_reg[1];
        wz_reg <= qh_reg[3] * qh_reg[2];

        c3_m_reg[0][0] <= sq_reg[3] + sq_reg[0];
        c3_d_reg[0]    <= sq_reg[1] + sq_reg[2];
        c3_m_reg[1][1] <= sq_reg[3] + sq_reg[1];
        c3_d_reg[1]    <= sq_reg[0] + sq_reg[2];
        c3_m_reg[2][2] <= sq_reg[3] + sq_reg[2];
        c3_d_reg[2]    <= sq_reg[0] + sq_reg[1];
        c3_m_reg[0][1] <= (xy_reg - wz_reg) <<< 1;
        c3_m_reg[0][2] <= (xz_reg + wy_reg) <<< 1;
        c3_m_reg[1][0] <= (xy_reg + wz_reg) <<< 1;
        c3_m_reg[1][2] <= (yz_reg - wx_reg) <<< 1;
        c3_m_reg[2][0] <= (xz_reg - wy_reg) <<< 1;
        c3_m_reg[2][1] <= (yz_reg + wx_reg) <<< 1;

        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                m_reg[i][j] <= (i == j) ? (c3_m_reg[i][j] - c3_d_reg[i]) : c3_m_reg[i][j];
            end
        end
        // The divisor is twice the squared norm, for rounding to nearest.
        dvs_reg  <= MW'(c3_m_reg[0][0] + c3_d_reg[0]) << 1;
        zero_reg <= (c3_m_reg[0][0] + c3_d_reg[0]) == '0;
    end

    // Valid bits of the point pipeline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < 5; s++)
            begin
                v_reg[s] <= 1'b0;
            end
            for (int k = 0; k <= QB; k++)
            begin
                dv_v_reg[k] <= 1'b0;
            end
            f1_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= point_valid && point_ready;
            for (int s = 1; s < 5; s++)
            begin
                v_reg[s] <= v_reg[s-1];
            end
            dv_v_reg[0] <= v_reg[4];
            for (int k = 1; k <= QB; k++)
            begin
                dv_v_reg[k] <= dv_v_reg[k-1];
            end
            f1_v_reg  <= dv_v_reg[QB];
            out_v_reg <= f1_v_reg;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            num[i]  = NW'({mag_reg[i], 1'b0}) + NW'(dvs_reg >> 1);
            osum[i] = SW'(f1_r_reg[i]) + SW'(offset_reg[i]);
            if (osum[i] > OUT_MAX)
            begin
                osat[i] = OUT_MAX[CW-1:0];
            end
            else if (osum[i] < OUT_MIN)
            begin
                osat[i] = OUT_MIN[CW-1:0];
            end
            else
            begin
                osat[i] = osum[i][CW-1:0];
            end
        end
    end

    // Point path: products, row sums, magnitude, one quotient bit per stage, offset, clamp.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg[0] <= point.point_x;
            p_reg[1] <= point.point_y;
            p_reg[2] <= point.point_z;
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    ph_reg[i][j]   <= $signed(m_reg[i][j][MW-1:HW]) * p_reg[j];
                    pl_reg[i][j]   <= $signed({1'b0, m_reg[i][j][HW-1:0]}) * p_reg[j];
                    prod_reg[i][j] <= (AW'(ph_reg[i][j]) <<< HW) + AW'(pl_reg[i][j]);
                end
                acc_reg[i] <= prod_reg[i][0] + prod_reg[i][1] + prod_reg[i][2];
                neg_reg[i] <= acc_reg[i][AW-1];
                mag_reg[i] <= acc_reg[i][AW-1] ? (AW-1)'(-acc_reg[i]) : acc_reg[i][AW-2:0];

                dv_rem_reg[0][i] <= num[i][NW-1:QB];
                dv_low_reg[0][i] <= num[i][QB-1:0];
                dv_quo_reg[0][i] <= '0;
                dv_neg_reg[0][i] <= neg_reg[i];
                for (int k = 1; k <= QB; k++)
                begin
                    if ({dv_rem_reg[k-1][i], dv_low_reg[k-1][i][QB-1]} >= {1'b0, dvs_reg})
                    begin
                        dv_rem_reg[k][i] <= RW'({dv_rem_reg[k-1][i], dv_low_reg[k-1][i][QB-1]}
                                                - {1'b0, dvs_reg});
                        dv_quo_reg[k][i] <= {dv_quo_reg[k-1][i][QB-2:0], 1'b1};
                    end
                    else
                    begin
                        dv_rem_reg[k][i] <= {dv_rem_reg[k-1][i][RW-2:0],
                                             dv_low_reg[k-1][i][QB-1]};
                        dv_quo_reg[k][i] <= {dv_quo_reg[k-1][i][QB-2:0], 1'b0};
                    end
                    dv_low_reg[k][i] <= dv_low_reg[k-1][i] << 1;
                    dv_neg_reg[k][i] <= dv_neg_reg[k-1][i];
                end

                f1_r_reg[i] <= dv_neg_reg[QB][i] ? -$signed({1'b0, dv_quo_reg[QB][i]})
                                                 : $signed({1'b0, dv_quo_reg[QB][i]});
            end
            out_reg.out_x        <= zero_reg ? '0 : osat[0];
            out_reg.out_y        <= zero_reg ? '0 : osat[1];
            out_reg.out_z        <= zero_reg ? '0 : osat[2];
            out_reg.bad_rotation <= zero_reg;
        end
    end

    `PPT_ASSERT_NOW(a_accept_settled, point_valid && point_ready, settle_cnt_reg == 3'd0)
    `PPT_ASSERT_NEXT(a_cfg_blocks_points, cfg_valid && cfg_ready, !point_ready)
    `PPT_ASSERT_NOW(a_bad_gives_zero, result_valid && result.bad_rotation,
                    result.out_x == '0 && result.out_y == '0 && result.out_z == '0)
    `PPT_ASSERT_NOW(a_rem_below_divisor, dv_v_reg[QB] && !zero_reg,
                    dv_rem_reg[QB][0] < dvs_reg)

endmodule

`default_nettype wire
